// ----- rtl/bmhq_pkg.sv -----
// shared types, constants and codes for the binary min-heap queue
`default_nettype none

package bmhq_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int CH_W     = IDX_W + 2;
  localparam int KEY_W    = 32;
  localparam int ENTRY_W  = 7;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_LOAD   = 2'd2;
  localparam logic [1:0] OP_BUILD  = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [1:0]              opcode;
    logic signed [KEY_W-1:0] key_in;
  } in_item_t;

  typedef struct packed {
    logic signed [KEY_W-1:0] key_out;
    logic [ENTRY_W-1:0]      entry_count;
    logic [1:0]              status;
  } out_item_t;

  typedef enum logic [2:0] {
    ADDR_ZERO,
    ADDR_PARENT,
    ADDR_CNT,
    ADDR_CHILD,
    ADDR_RIGHT,
    ADDR_BLD,
    ADDR_NCHILD
  } rd_sel_t;

  typedef enum logic [1:0] {
    WSRC_X,
    WSRC_RDATA,
    WSRC_CVAL
  } wr_sel_t;

  typedef enum logic [2:0] {
    IDX_HOLD,
    IDX_CNT,
    IDX_PARENT,
    IDX_ZERO,
    IDX_CIDX,
    IDX_BLD
  } idx_sel_t;

  typedef struct packed {
    logic     take;
    logic     rd_en;
    rd_sel_t  rd_sel;
    logic     wr_en;
    wr_sel_t  wr_sel;
    idx_sel_t idx_sel;
    logic     cnt_inc;
    logic     cnt_dec;
    logic     x_ld;
    logic     res_ld;
    logic     chl_child;
    logic     chl_nchild;
    logic     cval_ld;
    logic     cval_pick;
    logic     bld_ld;
    logic     bld_dec;
    logic     set_full;
    logic     set_empty;
    logic     out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       full;
    logic       cnt_zero;
    logic       idx_zero;
    logic       up_gt;
    logic       has_child;
    logic       has_right;
    logic       c_lt;
    logic       nxt_has_child;
    logic       bld_zero;
  } dp_sts_t;

endpackage

`default_nettype wire

// ----- rtl/bmhq_datapath.sv -----
// heap memory, index registers, comparators and result register
`default_nettype none

module bmhq_datapath (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire bmhq_pkg::in_item_t  in_data,
  input  wire bmhq_pkg::dp_cmd_t   cmd,
  output bmhq_pkg::dp_sts_t        sts,
  output bmhq_pkg::out_item_t      out_data
);
  import bmhq_pkg::*;

  logic signed [KEY_W-1:0] mem_r [CAPACITY];
  logic signed [KEY_W-1:0] rdata_r;

  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [1:0]              op_r;
  logic signed [KEY_W-1:0] x_r;
  logic signed [KEY_W-1:0] res_r;
  logic [1:0]              st_r;
  logic [IDX_W-1:0]        idx_r, idx_nxt;
  logic [CH_W-1:0]         chl_r;
  logic signed [KEY_W-1:0] cval_r;
  logic [IDX_W-1:0]        cidx_r;
  logic [IDX_W-1:0]        bld_r;
  out_item_t               out_r;

  logic [IDX_W-1:0]        idx_m1, parent, bld_m1, raddr;
  logic [CH_W-1:0]         child, right, nchild, cnt_ext;
  logic signed [KEY_W-1:0] wdata;

  assign idx_m1  = idx_r - IDX_W'(1);
  assign parent  = idx_m1 >> 1;
  assign bld_m1  = bld_r - IDX_W'(1);
  assign child   = CH_W'({idx_r, 1'b1});
  assign nchild  = CH_W'({cidx_r, 1'b1});
  assign right   = chl_r + CH_W'(1);
  assign cnt_ext = CH_W'(cnt_r);

  always_comb begin
    unique case (cmd.rd_sel)
      ADDR_ZERO:   raddr = '0;
      ADDR_PARENT: raddr = parent;
      ADDR_CNT:    raddr = cnt_r[IDX_W-1:0];
      ADDR_CHILD:  raddr = child[IDX_W-1:0];
      ADDR_RIGHT:  raddr = right[IDX_W-1:0];
      ADDR_BLD:    raddr = bld_m1;
      ADDR_NCHILD: raddr = nchild[IDX_W-1:0];
      default:     raddr = '0;
    endcase
  end

  always_comb begin
    unique case (cmd.wr_sel)
      WSRC_X:     wdata = x_r;
      WSRC_RDATA: wdata = rdata_r;
      WSRC_CVAL:  wdata = cval_r;
      default:    wdata = x_r;
    endcase
  end

  // writes always land at the current hole position
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem_r[idx_r] <= wdata;
    end
    if (cmd.rd_en) begin
      rdata_r <= mem_r[raddr];
    end
  end

  always_comb begin
    unique case (cmd.idx_sel)
      IDX_HOLD:   idx_nxt = idx_r;
      IDX_CNT:    idx_nxt = cnt_r[IDX_W-1:0];
      IDX_PARENT: idx_nxt = parent;
      IDX_ZERO:   idx_nxt = '0;
      IDX_CIDX:   idx_nxt = cidx_r;
      IDX_BLD:    idx_nxt = bld_m1;
      default:    idx_nxt = idx_r;
    endcase
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.cnt_inc) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (cmd.cnt_dec) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    if (cmd.take) begin
      op_r  <= in_data.opcode;
      x_r   <= in_data.key_in;
      res_r <= '0;
      st_r  <= ST_OK;
    end else begin
      if (cmd.x_ld) begin
        x_r <= rdata_r;
      end
      if (cmd.res_ld) begin
        res_r <= rdata_r;
      end
      if (cmd.set_full) begin
        st_r <= ST_FULL;
      end else if (cmd.set_empty) begin
        st_r <= ST_EMPTY;
      end
    end
    priority if (cmd.chl_child) begin
      chl_r <= child;
    end else if (cmd.chl_nchild) begin
      chl_r <= nchild;
    end
    // left child first, right child replaces it only when strictly smaller
    if (cmd.cval_ld) begin
      cval_r <= rdata_r;
      cidx_r <= chl_r[IDX_W-1:0];
    end else if (cmd.cval_pick && (rdata_r < cval_r)) begin
      cval_r <= rdata_r;
      cidx_r <= right[IDX_W-1:0];
    end
    if (cmd.bld_ld) begin
      bld_r <= IDX_W'(cnt_r >> 1);
    end else if (cmd.bld_dec) begin
      bld_r <= bld_m1;
    end
    if (cmd.out_load) begin
      out_r.key_out     <= res_r;
      out_r.entry_count <= ENTRY_W'(cnt_r);
      out_r.status      <= st_r;
    end
  end

  assign sts.op            = op_r;
  assign sts.full          = (cnt_r == CNT_W'(CAPACITY));
  assign sts.cnt_zero      = (cnt_r == '0);
  assign sts.idx_zero      = (idx_r == '0);
  assign sts.up_gt         = (rdata_r > x_r);
  assign sts.has_child     = (child < cnt_ext);
  assign sts.has_right     = (right < cnt_ext);
  assign sts.c_lt          = (cval_r < x_r);
  assign sts.nxt_has_child = (nchild < cnt_ext);
  assign sts.bld_zero      = (bld_r == '0);

  assign out_data = out_r;

endmodule

`default_nettype wire

// ----- rtl/bmhq_ctrl.sv -----
// sequencer for insert, remove, load and build over the heap datapath
`default_nettype none

module bmhq_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  output logic                   out_valid,
  input  wire logic              out_stall,
  input  wire bmhq_pkg::dp_sts_t sts,
  output bmhq_pkg::dp_cmd_t      cmd
);
  import bmhq_pkg::*;

  typedef enum logic [13:0] {
    S_IDLE     = 14'b00000000000001,
    S_DISPATCH = 14'b00000000000010,
    S_UP_RD    = 14'b00000000000100,
    S_UP_CMP   = 14'b00000000001000,
    S_RM_ROOT  = 14'b00000000010000,
    S_RM_LAST  = 14'b00000000100000,
    S_BLD_NEXT = 14'b00000001000000,
    S_BLD_X    = 14'b00000010000000,
    S_SD_START = 14'b00000100000000,
    S_SD_L     = 14'b00001000000000,
    S_SD_R     = 14'b00010000000000,
    S_SD_CMP   = 14'b00100000000000,
    S_SD_END   = 14'b01000000000000,
    S_FIN      = 14'b10000000000000
  } state_t;

  state_t state_r, state_nxt, sd_done;
  logic   out_valid_r, out_valid_nxt;

  // where a finished sift-down returns to
  assign sd_done = (sts.op == OP_BUILD) ? S_BLD_NEXT : S_FIN;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.take  = 1'b1;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (sts.op)
          OP_INSERT, OP_LOAD: begin
            if (sts.full) begin
              cmd.set_full = 1'b1;
              state_nxt    = S_FIN;
            end else begin
              cmd.idx_sel = IDX_CNT;
              cmd.cnt_inc = 1'b1;
              state_nxt   = S_UP_RD;
            end
          end
          OP_REMOVE: begin
            if (sts.cnt_zero) begin
              cmd.set_empty = 1'b1;
              state_nxt     = S_FIN;
            end else begin
              cmd.rd_en   = 1'b1;
              cmd.rd_sel  = ADDR_ZERO;
              cmd.cnt_dec = 1'b1;
              state_nxt   = S_RM_ROOT;
            end
          end
          default: begin
            cmd.bld_ld = 1'b1;
            state_nxt  = S_BLD_NEXT;
          end
        endcase
      end
      S_UP_RD: begin
        if (sts.op == OP_LOAD || sts.idx_zero) begin
          cmd.wr_en  = 1'b1;
          cmd.wr_sel = WSRC_X;
          state_nxt  = S_FIN;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = ADDR_PARENT;
          state_nxt  = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        cmd.wr_en = 1'b1;
        if (sts.up_gt) begin
          // parent moves down into the hole
          cmd.wr_sel  = WSRC_RDATA;
          cmd.idx_sel = IDX_PARENT;
          state_nxt   = S_UP_RD;
        end else begin
          cmd.wr_sel = WSRC_X;
          state_nxt  = S_FIN;
        end
      end
      S_RM_ROOT: begin
        cmd.res_ld = 1'b1;
        if (sts.cnt_zero) begin
          state_nxt = S_FIN;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = ADDR_CNT;
          state_nxt  = S_RM_LAST;
        end
      end
      S_RM_LAST: begin
        cmd.x_ld    = 1'b1;
        cmd.idx_sel = IDX_ZERO;
        state_nxt   = S_SD_START;
      end
      S_BLD_NEXT: begin
        if (sts.bld_zero) begin
          state_nxt = S_FIN;
        end else begin
          cmd.bld_dec = 1'b1;
          cmd.idx_sel = IDX_BLD;
          cmd.rd_en   = 1'b1;
          cmd.rd_sel  = ADDR_BLD;
          state_nxt   = S_BLD_X;
        end
      end
      S_BLD_X: begin
        cmd.x_ld  = 1'b1;
        state_nxt = S_SD_START;
      end
      S_SD_START: begin
        if (sts.has_child) begin
          cmd.rd_en     = 1'b1;
          cmd.rd_sel    = ADDR_CHILD;
          cmd.chl_child = 1'b1;
          state_nxt     = S_SD_L;
        end else begin
          cmd.wr_en  = 1'b1;
          cmd.wr_sel = WSRC_X;
          state_nxt  = sd_done;
        end
      end
      S_SD_L: begin
        cmd.cval_ld = 1'b1;
        if (sts.has_right) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = ADDR_RIGHT;
          state_nxt  = S_SD_R;
        end else begin
          state_nxt = S_SD_CMP;
        end
      end
      S_SD_R: begin
        cmd.cval_pick = 1'b1;
        state_nxt     = S_SD_CMP;
      end
      S_SD_CMP: begin
        cmd.wr_en = 1'b1;
        if (sts.c_lt) begin
          // smaller child moves up, fetch its left child right away
          cmd.wr_sel  = WSRC_CVAL;
          cmd.idx_sel = IDX_CIDX;
          if (sts.nxt_has_child) begin
            cmd.rd_en      = 1'b1;
            cmd.rd_sel     = ADDR_NCHILD;
            cmd.chl_nchild = 1'b1;
            state_nxt      = S_SD_L;
          end else begin
            state_nxt = S_SD_END;
          end
        end else begin
          cmd.wr_sel = WSRC_X;
          state_nxt  = sd_done;
        end
      end
      S_SD_END: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = WSRC_X;
        state_nxt  = sd_done;
      end
      S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

// ----- rtl/binary_min_heap_queue.sv -----
// top level of the binary min-heap priority queue
// Usage: an input transfer carries an opcode (insert, remove minimum, load
// unordered, build heap) and a signed 32-bit key. Every input transfer gives
// exactly one output transfer with the removed key (zero unless a remove
// succeeds), the entry count after the operation and a status (ok, empty on
// remove, full on insert or load). A failed operation leaves the heap as is.
// Memory: one array with one read port, one write port and registered read data,
// so each heap level that an insert moves up or a sift-down passes takes its own
// reads, compare and write. A load writes the key at the end without moving it;
// a build sifts down every node with children, from the last one back to the root.
// One item is worked on at a time; in_stall is high from the transfer until
// the result is in the output register, and the next transfer can follow at once.
// The output register holds one result while the next item is processed; if
// the receiver still stalls when that second result is ready, the block waits.
// Reset (synchronous, rst_n low) empties the heap and drops any result not
// yet taken; the memory itself is not cleared.
`default_nettype none

module binary_min_heap_queue (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire bmhq_pkg::in_item_t   in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output bmhq_pkg::out_item_t       out_data
);
  import bmhq_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  bmhq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  bmhq_datapath u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule

`default_nettype wire

// ----- dv/binary_min_heap_queue_test.sv -----
// self-checking testbench for the binary min-heap queue: heap mirror, random ops, backpressure
`timescale 1ns / 1ps

module binary_min_heap_queue_test;
  import bmhq_pkg::*;

  localparam int unsigned HEAP_CAP     = bmhq_pkg::CAPACITY;
  localparam int unsigned CYCLE_LIMIT  = 1000000;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned SETTLE_CYCLES = 400;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  binary_min_heap_queue u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // mirror of the heap contents, updated at each accepted input transfer
  logic signed [KEY_W-1:0] mirror_heap [HEAP_CAP];
  int unsigned             mirror_fill = 0;
  out_item_t               pending_results [$];

  bit          idle_on = 1'b1;
  bit          hold_req = 1'b0;
  int unsigned hold_left = 0;
  int unsigned cycle_count = 0;
  int unsigned n_sent = 0;
  int unsigned n_checked = 0;
  int unsigned n_errors = 0;
  int unsigned n_full = 0;
  int unsigned n_empty = 0;
  int unsigned n_builds = 0;

  function automatic void mirror_sift_down(int unsigned start, int unsigned n);
    int unsigned i;
    int unsigned j;
    logic signed [KEY_W-1:0] x;
    i = start;
    j = 2 * start + 1;
    x = mirror_heap[start];
    if (j + 1 < n && mirror_heap[j + 1] < mirror_heap[j]) j++;
    while (j < n && mirror_heap[j] < x) begin
      mirror_heap[i] = mirror_heap[j];
      i = j;
      j = 2 * j + 1;
      if (j + 1 < n && mirror_heap[j + 1] < mirror_heap[j]) j++;
    end
    mirror_heap[i] = x;
  endfunction

  // applies one operation to the mirror and returns the result it must produce
  function automatic out_item_t heap_apply(logic [1:0] op, logic signed [KEY_W-1:0] key);
    out_item_t   r;
    int unsigned p;
    int unsigned e;
    r = '0;
    r.status = ST_OK;
    case (op)
      OP_INSERT, OP_LOAD: begin
        if (mirror_fill >= HEAP_CAP) begin
          r.status = ST_FULL;
        end else begin
          p = mirror_fill;
          mirror_fill++;
          if (op == OP_INSERT) begin
            while (p > 0 && mirror_heap[(p - 1) / 2] > key) begin
              mirror_heap[p] = mirror_heap[(p - 1) / 2];
              p = (p - 1) / 2;
            end
          end
          mirror_heap[p] = key;
        end
      end
      OP_REMOVE: begin
        if (mirror_fill == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.key_out = mirror_heap[0];
          mirror_fill--;
          if (mirror_fill > 0) begin
            mirror_heap[0] = mirror_heap[mirror_fill];
            mirror_sift_down(0, mirror_fill);
          end
        end
      end
      default: begin
        e = mirror_fill / 2;
        while (e > 0) begin
          e--;
          mirror_sift_down(e, mirror_fill);
        end
      end
    endcase
    r.entry_count = ENTRY_W'(mirror_fill);
    return r;
  endfunction

  // mix of full-range keys, a narrow band that forces ties, and the extremes
  function automatic logic signed [KEY_W-1:0] pick_key();
    int unsigned             sel;
    logic signed [KEY_W-1:0] k;
    sel = $urandom_range(0, 99);
    if (sel < 15) begin
      case ($urandom_range(0, 3))
        0:       k = 32'sh7fffffff;
        1:       k = 32'sh80000000;
        2:       k = '0;
        default: k = -1;
      endcase
    end else if (sel < 45) begin
      k = $urandom_range(0, 16);
      k = k - 8;
    end else begin
      k = $urandom;
    end
    return k;
  endfunction

  task automatic send_item(logic [1:0] op, logic signed [KEY_W-1:0] key);
    in_item_t item;
    item.opcode = op;
    item.key_in = key;
    @(negedge clk);
    while (idle_on && $urandom_range(0, 99) < 23) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(heap_apply(op, key));
    n_sent++;
    if (op == OP_BUILD) n_builds++;
  endtask

  // sender stops and waits until every expected result has come back
  task automatic wait_for_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_edge_cases();
    send_item(OP_REMOVE, pick_key());   // remove from empty heap
    send_item(OP_BUILD, pick_key());    // build on empty heap
    send_item(OP_LOAD, 32'sh7fffffff);
    send_item(OP_BUILD, 32'sh80000000); // build with a single entry
    send_item(OP_INSERT, 32'sh80000000);
    send_item(OP_INSERT, '0);
    send_item(OP_INSERT, -1);
    send_item(OP_INSERT, -1);           // duplicate key
    send_item(OP_LOAD, 32'sh80000000);
    send_item(OP_LOAD, 32'sh7fffffff);
    send_item(OP_INSERT, 1);
    send_item(OP_BUILD, -1);
    repeat (9) send_item(OP_REMOVE, pick_key());
  endtask

  task automatic test_capacity_limits();
    repeat (2) begin
      while (mirror_fill < HEAP_CAP)
        send_item($urandom_range(0, 2) != 0 ? OP_INSERT : OP_LOAD, pick_key());
      send_item(OP_INSERT, pick_key());
      send_item(OP_LOAD, pick_key());
      send_item(OP_INSERT, 32'sh80000000);
      send_item(OP_BUILD, pick_key());
      while (mirror_fill > 0) send_item(OP_REMOVE, pick_key());
      send_item(OP_REMOVE, pick_key());
    end
  endtask

  task automatic test_load_and_build();
    int unsigned n;
    repeat (12) begin
      n = ($urandom_range(0, 4) == 0) ? HEAP_CAP : $urandom_range(0, 20);
      repeat (n) send_item(OP_LOAD, pick_key());
      send_item(OP_BUILD, pick_key());
      repeat ($urandom_range(0, 3)) send_item(OP_INSERT, pick_key());
      while (mirror_fill > 0) send_item(OP_REMOVE, pick_key());
    end
  endtask

  // rounds with different remove pressure so the fill level wanders
  task automatic test_random_mix(int unsigned n_items);
    int unsigned done_items;
    int unsigned rm_pct;
    int unsigned r;
    done_items = 0;
    while (done_items < n_items) begin
      rm_pct = $urandom_range(10, 60);
      repeat (40) begin
        r = $urandom_range(0, 99);
        if (r < rm_pct)           send_item(OP_REMOVE, pick_key());
        else if (r < rm_pct + 8)  send_item(OP_BUILD, pick_key());
        else if (r % 3 == 0)      send_item(OP_LOAD, pick_key());
        else                      send_item(OP_INSERT, pick_key());
      end
      done_items += 40;
    end
  endtask

  // receiver holds off while the sender keeps offering, so the block backs up
  task automatic test_output_holdoff();
    hold_req = 1'b1;
    repeat (8) send_item(OP_INSERT, pick_key());
    repeat (4) send_item(OP_REMOVE, pick_key());
  endtask

  task automatic test_back_to_back();
    idle_on = 1'b0;
    test_random_mix(240);
    wait_for_results();
    idle_on = 1'b1;
  endtask

  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= idle_on && ($urandom_range(0, 99) < 23);
    end
  end

  always @(posedge clk) begin : check_results
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result transfer, key_out %0d count %0d status %0d",
                 $time, out_data.key_out, out_data.entry_count, out_data.status);
        n_errors++;
      end else begin
        want = pending_results.pop_front();
        n_checked++;
        if (want.status == ST_FULL) n_full++;
        if (want.status == ST_EMPTY) n_empty++;
        if (out_data.key_out !== want.key_out) begin
          $display("%0t: key_out mismatch, expected %0d, actual %0d",
                   $time, want.key_out, out_data.key_out);
          n_errors++;
        end
        if (out_data.entry_count !== want.entry_count) begin
          $display("%0t: entry_count mismatch, expected %0d, actual %0d",
                   $time, want.entry_count, out_data.entry_count);
          n_errors++;
        end
        if (out_data.status !== want.status) begin
          $display("%0t: status mismatch, expected %0d, actual %0d",
                   $time, want.status, out_data.status);
          n_errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d results outstanding",
               $time, cycle_count, pending_results.size());
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_edge_cases();
    test_capacity_limits();
    test_load_and_build();
    wait_for_results();
    test_output_holdoff();
    wait_for_results();
    test_random_mix(200);
    test_back_to_back();
    test_random_mix(280);
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d input transfers and %0d checked results in %0d cycles",
             n_sent, n_checked, cycle_count);
    $display("including %0d builds, %0d full rejections, %0d empty removes",
             n_builds, n_full, n_empty);
    if (n_errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
